// ===== hw/rtl/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
// Used by the top level and the iterative divider; depends on nothing.
package bsa_pkg;

    localparam int OFF_W      = 19;
    localparam int CAP_W      = 14;
    localparam int SIZE_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int DIV_CNT_W  = $clog2(OFF_W + 1);

    localparam logic [CAP_W-1:0]  CAP_RESET  = 14'd8192;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES  = 2'd1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC_SET,
        ST_ALLOC_MUL,
        ST_DIV_SLOT,
        ST_FREE_WR,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic              start;
        logic [OFF_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [OFF_W-1:0]  quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/bsa_map_ram.sv =====
// Bitmap storage: one write port and one read port with registered read data.
// Generic; depends on no package.
module bsa_map_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64,
    parameter int AW    = 7
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bsa_divider.sv =====
// Restoring divider, one quotient bit per cycle, that turns a byte offset into a slot.
// Depends on bsa_pkg for widths and the request and response structs.
module bsa_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  bsa_pkg::div_req_t req,
    output bsa_pkg::div_rsp_t rsp
);
    import bsa_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [OFF_W-1:0]     quo_reg, quo_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [SIZE_W-1:0]    div_reg, div_next;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;
    logic                 ge;

    // The dividend shifts out of the top of quo_reg while quotient bits enter below.
    assign trial = {rem_reg, quo_reg[OFF_W-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (busy_reg) begin
            quo_next = {quo_reg[OFF_W-2:0], ge};
            rem_next = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(OFF_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/bitmap_slot_allocator.sv =====
// Bitmap slot allocator. An allocate reads map words from the search hint, one word per cycle,
// until it finds a word with a clear bit, then sets that bit and multiplies the slot by the
// object size; a failed allocate reads all MAP_WORDS words. A free divides its offset in the
// one-bit-per-cycle divider, then does a map word read-modify-write, which it skips when the
// offset is beyond capacity. One request is in flight at a time.
// Reset and every register write rewrite all MAP_WORDS map words; requests wait for it.
module bitmap_slot_allocator #(
    parameter int MAP_WORDS = 128,
    parameter int WORD_BITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [bsa_pkg::OFF_W-1:0]          s_free_offset,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bsa_pkg::STATUS_W-1:0]       m_status,
    output logic [bsa_pkg::OFF_W-1:0]          m_slot_offset,
    output logic                               m_became_empty,
    output logic                               m_is_full,
    output logic                               m_is_empty,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bsa_pkg::*;

    localparam int TOTAL_SLOTS = MAP_WORDS * WORD_BITS;
    localparam int CNT_W  = $clog2(TOTAL_SLOTS + 1);
    localparam int WI_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BI_W   = $clog2(WORD_BITS);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int FCMP_W = (CNT_W > OFF_W) ? CNT_W : OFF_W;
    localparam int PROD_W = (CNT_W + SIZE_W > OFF_W) ? CNT_W + SIZE_W : OFF_W;

    fsm_state_t state_reg, state_next;

    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [WI_W-1:0]      hint_reg, hint_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [WI_W-1:0]      init_word_reg, init_word_next;
    logic [CNT_W-1:0]     init_base_reg, init_base_next;
    logic [WI_W-1:0]      chk_word_reg, chk_word_next;
    logic [WI_W-1:0]      visited_reg, visited_next;
    logic [WORD_BITS-1:0] data_reg, data_next;
    logic [WI_W-1:0]      word_reg, word_next;
    logic [BI_W-1:0]      bit_reg, bit_next;
    logic [CNT_W-1:0]     slot_reg, slot_next;
    logic [STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic [OFF_W-1:0]     pend_offset_reg, pend_offset_next;
    logic                 pend_bempty_reg, pend_bempty_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [OFF_W-1:0]     m_offset_reg, m_offset_next;
    logic                 m_bempty_reg, m_bempty_next;
    logic                 m_full_reg, m_full_next;
    logic                 m_empty_reg, m_empty_next;

    logic                 ram_wr_en;
    logic [WI_W-1:0]      ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [WI_W-1:0]      ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic                 cfg_write;
    logic                 in_accept;
    logic                 out_load;
    logic [CMP_W-1:0]     cap_ext;
    logic [CNT_W-1:0]     eff_cap;
    logic [SIZE_W-1:0]    eff_size;
    logic [WORD_BITS-1:0] init_word;
    logic [WORD_BITS-1:0] low_zero;
    logic [BI_W-1:0]      low_zero_idx;
    logic                 word_open;
    logic                 scan_last;
    logic                 slot_in_range;
    logic [PROD_W-1:0]    offset_prod;
    logic [WORD_BITS-1:0] clear_mask;

    bsa_map_ram #(
        .DEPTH(MAP_WORDS),
        .WIDTH(WORD_BITS),
        .AW   (WI_W)
    ) u_map_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    bsa_divider u_divider (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index == CFG_SLOT_CAPACITY || cfg_index == CFG_OBJECT_BYTES);
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign cap_ext  = CMP_W'(cap_reg);
    assign eff_cap  = (cap_ext > CMP_W'(TOTAL_SLOTS)) ? CNT_W'(TOTAL_SLOTS) : CNT_W'(cap_ext);
    assign eff_size = (size_reg == '0) ? SIZE_W'(1) : size_reg;

    // Initial contents of one map word: slots at or beyond the capacity are marked used.
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            init_word[b] = (init_base_reg + CNT_W'(b)) >= eff_cap;
        end
    end

    // Lowest clear bit: isolate it with one add, then encode the one-hot result.
    assign low_zero = ~data_reg & (data_reg + WORD_BITS'(1));
    always_comb begin
        low_zero_idx = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (low_zero[b]) begin
                low_zero_idx = low_zero_idx | BI_W'(b);
            end
        end
    end

    assign word_open     = (ram_rd_data != '1);
    assign scan_last     = (visited_reg == WI_W'(MAP_WORDS - 1));
    assign slot_in_range = FCMP_W'(div_rsp.quotient) < FCMP_W'(eff_cap);
    assign offset_prod   = PROD_W'(slot_reg) * PROD_W'(eff_size);
    assign clear_mask    = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (init_word_reg == WI_W'(MAP_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = (s_action == ACT_FREE) ? ST_DIV_SLOT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (word_open) begin
                    state_next = ST_ALLOC_SET;
                end else if (scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_ALLOC_SET: state_next = ST_ALLOC_MUL;
            ST_ALLOC_MUL: state_next = ST_DONE;
            ST_DIV_SLOT: begin
                if (div_rsp.done) begin
                    state_next = slot_in_range ? ST_FREE_WR : ST_DONE;
                end
            end
            ST_FREE_WR: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
        if (cfg_write) begin
            state_next = ST_INIT;
        end
    end

    // Datapath, memory and divider control.
    always_comb begin
        cap_next         = cap_reg;
        size_next        = size_reg;
        hint_next        = hint_reg;
        count_next       = count_reg;
        init_word_next   = init_word_reg;
        init_base_next   = init_base_reg;
        chk_word_next    = chk_word_reg;
        visited_next     = visited_reg;
        data_next        = data_reg;
        word_next        = word_reg;
        bit_next         = bit_reg;
        slot_next        = slot_reg;
        pend_status_next = pend_status_reg;
        pend_offset_next = pend_offset_reg;
        pend_bempty_next = pend_bempty_reg;
        m_status_next    = m_status_reg;
        m_offset_next    = m_offset_reg;
        m_bempty_next    = m_bempty_reg;
        m_full_next      = m_full_reg;
        m_empty_next     = m_empty_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = init_word_reg;
        ram_wr_data      = init_word;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = hint_reg;
        div_req.start    = 1'b0;
        div_req.dividend = s_free_offset;
        div_req.divisor  = eff_size;

        case (state_reg)
            ST_INIT: begin
                ram_wr_en      = 1'b1;
                init_word_next = init_word_reg + WI_W'(1);
                init_base_next = init_base_reg + CNT_W'(WORD_BITS);
            end
            ST_IDLE: begin
                if (in_accept) begin
                    pend_status_next = STATUS_OK;
                    pend_offset_next = '0;
                    pend_bempty_next = 1'b0;
                    if (s_action == ACT_FREE) begin
                        div_req.start = 1'b1;
                    end else begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = hint_reg;
                        chk_word_next = hint_reg;
                        visited_next  = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (word_open) begin
                    data_next = ram_rd_data;
                    word_next = chk_word_reg;
                end else if (scan_last) begin
                    pend_status_next = STATUS_FULL;
                end else begin
                    // Wrap from the last word to word 0 and keep reading one word a cycle.
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = (chk_word_reg == WI_W'(MAP_WORDS - 1)) ?
                                    '0 : chk_word_reg + WI_W'(1);
                    chk_word_next = ram_rd_addr;
                    visited_next  = visited_reg + WI_W'(1);
                end
            end
            ST_ALLOC_SET: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = word_reg;
                ram_wr_data = data_reg | low_zero;
                hint_next   = word_reg;
                count_next  = count_reg + CNT_W'(1);
                slot_next   = CNT_W'(CNT_W'(word_reg) * CNT_W'(WORD_BITS)) +
                              CNT_W'(low_zero_idx);
            end
            ST_ALLOC_MUL: begin
                pend_offset_next = offset_prod[OFF_W-1:0];
            end
            ST_DIV_SLOT: begin
                if (div_rsp.done) begin
                    if (slot_in_range) begin
                        // WORD_BITS is a power of two, so the slot splits into word and bit
                        // by its index bits.
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = div_rsp.quotient[BI_W +: WI_W];
                        word_next   = div_rsp.quotient[BI_W +: WI_W];
                        bit_next    = div_rsp.quotient[BI_W-1:0];
                    end else begin
                        pend_status_next = STATUS_RANGE;
                    end
                end
            end
            ST_FREE_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = word_reg;
                ram_wr_data = ram_rd_data & ~clear_mask;
                if (word_reg < hint_reg) begin
                    hint_next = word_reg;
                end
                // A double free can push the count below the set bits; it stops at zero.
                if (count_reg != '0) begin
                    count_next = count_reg - CNT_W'(1);
                end
                pend_bempty_next = (count_reg == CNT_W'(1));
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next  = 1'b1;
                    m_status_next = pend_status_reg;
                    m_offset_next = pend_offset_reg;
                    m_bempty_next = pend_bempty_reg;
                    m_full_next   = (count_reg == eff_cap);
                    m_empty_next  = (count_reg == '0);
                end
            end
            default: begin
            end
        endcase

        if (cfg_write) begin
            if (cfg_index == CFG_SLOT_CAPACITY) begin
                cap_next = cfg_data[CAP_W-1:0];
            end else begin
                size_next = cfg_data[SIZE_W-1:0];
            end
            init_word_next = '0;
            init_base_next = '0;
            hint_next      = '0;
            count_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            cap_reg       <= CAP_RESET;
            size_reg      <= SIZE_RESET;
            hint_reg      <= '0;
            count_reg     <= '0;
            init_word_reg <= '0;
            init_base_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            size_reg      <= size_next;
            hint_reg      <= hint_next;
            count_reg     <= count_next;
            init_word_reg <= init_word_next;
            init_base_reg <= init_base_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_word_reg    <= chk_word_next;
        visited_reg     <= visited_next;
        data_reg        <= data_next;
        word_reg        <= word_next;
        bit_reg         <= bit_next;
        slot_reg        <= slot_next;
        pend_status_reg <= pend_status_next;
        pend_offset_reg <= pend_offset_next;
        pend_bempty_reg <= pend_bempty_next;
        m_status_reg    <= m_status_next;
        m_offset_reg    <= m_offset_next;
        m_bempty_reg    <= m_bempty_next;
        m_full_reg      <= m_full_next;
        m_empty_reg     <= m_empty_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_offset  = m_offset_reg;
    assign m_became_empty = m_bempty_reg;
    assign m_is_full      = m_full_reg;
    assign m_is_empty     = m_empty_reg;

    // The used count never runs past the number of usable slots.
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= eff_cap)
        else $error("used count exceeds capacity");

    // Divider results arrive only while a free request waits on them.
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV_SLOT))
        else $error("divider finished outside a free request");

    // A slab can only become empty through a successful free.
    a_empty_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_became_empty) |-> (m_status == STATUS_OK && m_is_empty))
        else $error("became_empty without a successful free");

    // One request at a time: taking a request closes the input for the next cycle.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in flight");

endmodule

// ===== verif/tb_bitmap_slot_allocator.sv =====
// Self-checking testbench for the bitmap slot allocator: random and directed requests
// are checked against a predictor of the slot map, the search hint and the used count.
// Depends on bsa_pkg and bitmap_slot_allocator.
module tb_bitmap_slot_allocator;
    import bsa_pkg::*;

    localparam int MAP_WORDS = 128;
    localparam int WORD_BITS = 64;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct {
        logic             action;
        logic [OFF_W-1:0] free_offset;
    } slot_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    slot_offset;
        logic                became_empty;
        logic                is_full;
        logic                is_empty;
    } slot_result_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_action = ACT_ALLOC;
    logic [OFF_W-1:0]      s_free_offset = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [OFF_W-1:0]      m_slot_offset;
    logic                  m_became_empty;
    logic                  m_is_full;
    logic                  m_is_empty;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SLOT_CAPACITY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted allocator state and register values.
    logic [WORD_BITS-1:0] slot_bits [0:MAP_WORDS-1];
    int unsigned          hint_word;
    int unsigned          slots_used;
    logic [CAP_W-1:0]     cap_reg;
    logic [SIZE_W-1:0]    size_reg;

    slot_request_t pending_requests[$];
    slot_result_t  expected_results[$];
    int            owed = 0;
    bit            s_took = 1'b0;
    int            err_count = 0;
    bit            quiet = 1'b0;
    bit            hold_req = 1'b0;
    int unsigned   cycle_count = 0;

    bitmap_slot_allocator #(
        .MAP_WORDS(MAP_WORDS),
        .WORD_BITS(WORD_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_free_offset  (s_free_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot_offset  (m_slot_offset),
        .m_became_empty (m_became_empty),
        .m_is_full      (m_is_full),
        .m_is_empty     (m_is_empty),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned usable_slots();
        return (cap_reg > MAP_WORDS * WORD_BITS) ? MAP_WORDS * WORD_BITS : cap_reg;
    endfunction

    function automatic int unsigned stride_bytes();
        return (size_reg == '0) ? 1 : size_reg;
    endfunction

    // Clear the map and mark every slot at or past the capacity as taken.
    function automatic void map_reinit();
        int unsigned cap;
        int unsigned w;
        int unsigned lo;
        cap = usable_slots();
        for (w = 0; w < MAP_WORDS; w++) begin
            lo = w * WORD_BITS;
            if (lo + WORD_BITS <= cap) begin
                slot_bits[w] = '0;
            end else if (lo >= cap) begin
                slot_bits[w] = '1;
            end else begin
                slot_bits[w] = ~((64'd1 << (cap - lo)) - 64'd1);
            end
        end
        hint_word = 0;
        slots_used = 0;
    endfunction

    function automatic slot_result_t predict_request(input logic act,
                                                     input logic [OFF_W-1:0] off);
        slot_result_t r;
        int unsigned  start;
        int unsigned  cap;
        int unsigned  i;
        int unsigned  w;
        int unsigned  b;
        int unsigned  slot;
        bit           found;
        r = '0;
        r.status = STATUS_OK;
        start = hint_word;
        cap = usable_slots();
        found = 1'b0;
        slot = 0;
        if (act == ACT_ALLOC) begin
            // Scan from the hint to the top, then wrap around to word zero.
            for (i = 0; i < MAP_WORDS && !found; i++) begin
                w = (start + i) % MAP_WORDS;
                if (slot_bits[w] != '1) begin
                    for (b = 0; b < WORD_BITS && !found; b++) begin
                        if (!slot_bits[w][b]) begin
                            found = 1'b1;
                            slot_bits[w][b] = 1'b1;
                            hint_word = w;
                            slots_used++;
                            slot = w * WORD_BITS + b;
                        end
                    end
                end
            end
            if (found) begin
                r.slot_offset = OFF_W'(slot * stride_bytes());
            end else begin
                r.status = STATUS_FULL;
            end
        end else begin
            slot = off / stride_bytes();
            if (slot >= cap) begin
                r.status = STATUS_RANGE;
            end else begin
                w = slot / WORD_BITS;
                b = slot % WORD_BITS;
                slot_bits[w][b] = 1'b0;
                if (w < start) begin
                    hint_word = w;
                end
                if (slots_used > 0) begin
                    if (slots_used == 1) begin
                        r.became_empty = 1'b1;
                    end
                    slots_used--;
                end
            end
        end
        r.is_full = (slots_used == cap);
        r.is_empty = (slots_used == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Request driver: bursts of random length separated by random gaps, with no gaps while quiet.
    always @(negedge aclk) begin : request_driver
        slot_request_t nxt;
        int unsigned   burst_left;
        int unsigned   gap_left;
        if (!s_valid || s_took) begin
            if (gap_left > 0 && !quiet) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                nxt = pending_requests.pop_front();
                s_valid <= 1'b1;
                s_action <= nxt.action;
                s_free_offset <= nxt.free_offset;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 23);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: its own stall pattern, plus one long hold-off on demand.
    always @(negedge aclk) begin : result_receiver
        int unsigned hold_left;
        int unsigned pattern_left;
        int unsigned stall_pct;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(50, 100);
                case ($urandom_range(0, 3))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 25;
                    default: stall_pct = 60;
                endcase
            end else begin
                pattern_left--;
            end
            m_ready <= quiet || ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        slot_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_request(s_action, s_free_offset));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d, offset %0d",
                           m_status, m_slot_offset);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("slot_offset", want.slot_offset, m_slot_offset);
                    check_field("became_empty", want.became_empty, m_became_empty);
                    check_field("is_full", want.is_full, m_is_full);
                    check_field("is_empty", want.is_empty, m_is_empty);
                end
            end
        end
        s_took <= aresetn && s_valid && s_ready;
        owed <= expected_results.size();
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitmap_slot_allocator verification failed");
            $finish;
        end
    end

    task automatic queue_request(input logic act, input int unsigned off);
        slot_request_t r;
        r.action = act;
        r.free_offset = OFF_W'(off);
        pending_requests.push_back(r);
    endtask

    // Returns at a rising edge once every request has been answered.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_valid || owed != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        if (idx == CFG_SLOT_CAPACITY) begin
            cap_reg = data;
        end else if (idx == CFG_OBJECT_BYTES) begin
            size_reg = data[SIZE_W-1:0];
        end
        map_reinit();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Every register write restarts the allocator, so phases begin from a clean map.
    task automatic configure(input int unsigned cap, input logic [CFG_DATA_W-1:0] size_data);
        wait_drained();
        write_reg(CFG_SLOT_CAPACITY, CFG_DATA_W'(cap));
        write_reg(CFG_OBJECT_BYTES, size_data);
        @(posedge aclk);
    endtask

    // Mostly allocations and frees of plausibly live slots, switching between filling,
    // balanced and draining stretches; the rest are out-of-range and random frees.
    task automatic queue_random(input int unsigned n_items);
        int unsigned i;
        int unsigned mode_left;
        int unsigned alloc_pct;
        int unsigned allocs_made;
        int unsigned cap_e;
        int unsigned size_e;
        int unsigned slot;
        int unsigned lim;
        int unsigned roll;
        mode_left = 0;
        alloc_pct = 50;
        allocs_made = 0;
        cap_e = usable_slots();
        size_e = stride_bytes();
        for (i = 0; i < n_items; i++) begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(8, 60);
                case ($urandom_range(0, 2))
                    0: alloc_pct = 85;
                    1: alloc_pct = 55;
                    default: alloc_pct = 20;
                endcase
            end else begin
                mode_left--;
            end
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < alloc_pct) begin
                allocs_made++;
                queue_request(ACT_ALLOC, $urandom_range(0, 524287));
            end else if (roll < 75 && cap_e > 0) begin
                lim = (allocs_made + 8 < cap_e) ? allocs_made + 8 : cap_e;
                slot = $urandom_range(0, lim - 1);
                queue_request(ACT_FREE, slot * size_e + $urandom_range(0, size_e - 1));
            end else if (roll < 90) begin
                slot = cap_e + $urandom_range(0, 3);
                queue_request(ACT_FREE, slot * size_e + $urandom_range(0, size_e - 1));
            end else begin
                queue_request(ACT_FREE, $urandom_range(0, 524287));
            end
        end
    endtask

    initial begin
        int unsigned           ph;
        int unsigned           i;
        int unsigned           cap;
        int unsigned           sz;
        logic [CFG_DATA_W-1:0] size_data;

        cap_reg = CAP_RESET;
        size_reg = SIZE_RESET;
        map_reinit();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: double free, frees past capacity, the last slot, and
        // freeing down to an empty slab and beyond it.
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_ALLOC, 524287);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 8);
        queue_request(ACT_FREE, 9);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 524287);
        queue_request(ACT_FREE, 65535);
        queue_request(ACT_FREE, 65536);
        queue_request(ACT_FREE, 0);
        queue_request(ACT_FREE, 0);
        queue_request(ACT_FREE, 16);

        // Zero capacity reads as both full and empty.
        configure(0, CFG_DATA_W'(64));
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 0);

        // A single slot with a zero object size, which counts as one byte.
        configure(1, '0);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 1);
        queue_request(ACT_FREE, 0);

        for (ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 5))
                0: cap = $urandom_range(1, 40);
                1: cap = $urandom_range(41, 300);
                2: cap = 64 * $urandom_range(1, 4);
                3: cap = $urandom_range(301, 1000);
                4: cap = 8192;
                default: cap = $urandom_range(8193, 16383);
            endcase
            roll_size: begin
                case ($urandom_range(0, 9))
                    0: sz = 0;
                    1: sz = $urandom_range(65, 127);
                    default: sz = $urandom_range(1, 64);
                endcase
            end
            if (ph == 6) begin
                cap = 16383;
                sz = 64;
            end
            // Bits above the object size field must be ignored by the block.
            size_data = {($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 127)) : 7'd0,
                         7'(sz)};
            configure(cap, size_data);
            quiet = (ph == 4);
            if (ph == 3) begin
                queue_random(120);
                wait_drained();
                queue_random(120);
            end else begin
                queue_random(240);
            end
            if (ph == 1) begin
                hold_req = 1'b1;
            end
        end

        // A small slab of 127-byte objects, filled until allocations run into the full slab.
        configure(40, CFG_DATA_W'(127));
        quiet = 1'b0;
        for (i = 0; i < 42; i++) begin
            queue_request(ACT_ALLOC, $urandom_range(0, 524287));
        end

        wait_drained();
        repeat (200) @(posedge aclk);
        @(negedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("bitmap_slot_allocator verification clean");
        end else begin
            $display("bitmap_slot_allocator verification failed");
        end
        $finish;
    end

endmodule
